@@ hdl/vrt_pkg.sv @@
`default_nettype none
package vrt_pkg;

  localparam int GRID_SIDE_BITS_DEF = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int POS_W = 24;
  localparam int DIR_W = 18;
  localparam int VOX_W = 20;
  localparam int COUNT_W = 27;
  localparam int OUT_VOX_W = 10;

  localparam logic [2:0] JOB_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ORIG,
    S_DIV_GO,
    S_DIV_RUN,
    S_STEP,
    S_STEP_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       check;
    logic       grid_write;
    logic       div_start;
    logic       div_store;
    logic [2:0] div_job;
    logic       step;
    logic       set_hit;
    logic       set_miss;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_write;
    logic no_cast;
    logic solid;
    logic div_done;
    logic step_end;
  } status_t;

endpackage
`default_nettype wire

@@ hdl/vrt_ram.sv @@
`default_nettype none
module vrt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/vrt_div.sv @@
`default_nettype none
module vrt_div #(
  parameter int NW = 33,
  parameter int DVW = 18
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DVW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVW-1:0]   rem;
  logic [DVW-1:0]   den_q;
  logic [DVW:0]     rs;
  logic             fits;

  assign rs = {rem, quo[NW-1]};
  assign fits = rs >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= CNT_W'(NW);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      den_q <= den;
    end else if (running) begin
      rem <= fits ? DVW'(rs - {1'b0, den_q}) : rs[DVW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

@@ hdl/vrt_dp.sv @@
`default_nettype none
module vrt_dp #(
  parameter int GRID_SIDE_BITS = vrt_pkg::GRID_SIDE_BITS_DEF,
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire vrt_pkg::cmd_t               cmd,
  output vrt_pkg::status_t                 st,
  input  wire logic                        mode,
  input  wire logic [3:0]                  cell_x,
  input  wire logic [3:0]                  cell_y,
  input  wire logic [3:0]                  cell_z,
  input  wire logic                        solid_bit,
  input  wire logic signed [23:0]          origin_x,
  input  wire logic signed [23:0]          origin_y,
  input  wire logic signed [23:0]          origin_z,
  input  wire logic signed [17:0]          dir_x,
  input  wire logic signed [17:0]          dir_y,
  input  wire logic signed [17:0]          dir_z,
  input  wire logic signed [23:0]          max_distance,
  output logic                             hit_flag,
  output logic signed [9:0]                hit_x,
  output logic signed [9:0]                hit_y,
  output logic signed [9:0]                hit_z,
  output logic signed [1:0]                normal_x,
  output logic signed [1:0]                normal_y,
  output logic signed [1:0]                normal_z,
  output logic [23:0]                      hit_distance
);

  import vrt_pkg::*;

  localparam int G = GRID_SIDE_BITS;
  localparam int F = FRAC_BITS;
  localparam int SIDE = 1 << G;
  localparam int AW = 3 * G;
  localparam int NW = 2 * F + 1;
  localparam int TW = (2 * F + 2 > 25) ? 2 * F + 2 : 25;
  localparam int CW = (G > 4 ? G : 4) + 1;

  logic                    mode_q;
  logic [AW-1:0]           waddr_q;
  logic                    winr_q;
  logic                    solid_q;
  logic signed [VOX_W-1:0] vox [3];
  logic signed [VOX_W-1:0] vox_next [3];
  logic [F-1:0]            frac [3];
  logic signed [DIR_W-1:0] dir [3];
  logic signed [POS_W-1:0] md;
  logic [TW-1:0]           tmax [3];
  logic [TW-1:0]           tdel [3];
  logic [COUNT_W-1:0]      ms;
  logic [COUNT_W-1:0]      it;
  logic [TW-1:0]           travel;
  logic                    hav;
  logic [1:0]              hax;
  logic                    inr_q;
  logic [AW-1:0]           clr_addr;
  logic                    ram_rdata;

  logic signed [POS_W-1:0] org_in [3];
  logic signed [DIR_W-1:0] dir_in [3];
  logic signed [POS_W-1:0] org_sh [3];
  logic                    active [3];
  logic [TW:0]             key [3];
  logic [1:0]              ax;
  logic [CW-1:0]           cx, cy, cz;
  logic [COUNT_W-1:0]      md_u;
  logic [COUNT_W-1:0]      m3;
  logic [1:0]              job_axis;
  logic [F:0]              numf;
  logic [NW-1:0]           div_num;
  logic [DIR_W-1:0]        div_den;
  logic                    div_done;
  logic [NW-1:0]           div_quo;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;
  logic                    rd_inr;
  logic signed [VOX_W-1:0] rd_vox [3];

  function automatic logic in_grid(input logic signed [VOX_W-1:0] v);
    in_grid = !v[VOX_W-1] && (v < VOX_W'(SIDE));
  endfunction

  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  assign cx = CW'(cell_x);
  assign cy = CW'(cell_y);
  assign cz = CW'(cell_z);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      org_sh[a] = org_in[a] >>> F;
      active[a] = dir[a] != '0;
      key[a] = {!active[a], tmax[a]};
    end
    ax = 2'd0;
    if (key[1] < key[0]) begin
      ax = 2'd1;
    end
    if (key[2] < key[ax]) begin
      ax = 2'd2;
    end
    for (int a = 0; a < 3; a++) begin
      if (ax == 2'(a)) begin
        vox_next[a] = dir[a][DIR_W-1] ? vox[a] - VOX_W'(1) : vox[a] + VOX_W'(1);
      end else begin
        vox_next[a] = vox[a];
      end
      rd_vox[a] = cmd.step ? vox_next[a] : vox[a];
    end
  end

  assign rd_inr = in_grid(rd_vox[0]) && in_grid(rd_vox[1]) && in_grid(rd_vox[2]);
  assign ram_raddr = {rd_vox[2][G-1:0], rd_vox[1][G-1:0], rd_vox[0][G-1:0]};

  assign md_u = COUNT_W'(unsigned'(md));
  assign m3 = md_u + (md_u << 1) + COUNT_W'((1 << F) - 1);

  assign job_axis = cmd.div_job[2:1];
  always_comb begin
    if (dir[job_axis][DIR_W-1]) begin
      numf = {1'b0, frac[job_axis]};
      div_den = DIR_W'(-dir[job_axis]);
    end else begin
      numf = (F+1)'(1 << F) - {1'b0, frac[job_axis]};
      div_den = DIR_W'(dir[job_axis]);
    end
    if (cmd.div_job[0]) begin
      div_num = NW'(1) << (2 * F);
    end else begin
      div_num = {numf, F'(0)};
    end
  end

  vrt_div #(.NW(NW), .DVW(DIR_W)) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  assign ram_we = cmd.clear_step || (cmd.grid_write && winr_q);
  assign ram_waddr = cmd.clear_step ? clr_addr : waddr_q;

  vrt_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.clear_step ? 1'b0 : solid_q),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    inr_q <= rd_inr;
    if (cmd.load) begin
      mode_q <= mode;
      solid_q <= solid_bit;
      waddr_q <= {cz[G-1:0], cy[G-1:0], cx[G-1:0]};
      winr_q <= (cx < CW'(SIDE)) && (cy < CW'(SIDE)) && (cz < CW'(SIDE));
      md <= max_distance;
      for (int a = 0; a < 3; a++) begin
        vox[a] <= org_sh[a][VOX_W-1:0];
        frac[a] <= org_in[a][F-1:0];
        dir[a] <= dir_in[a];
      end
    end
    if (cmd.check) begin
      ms <= (m3 >> F) + COUNT_W'(3);
      it <= '0;
      travel <= '0;
      hav <= 1'b0;
    end
    if (cmd.div_store) begin
      if (cmd.div_job[0]) begin
        tdel[job_axis] <= TW'(div_quo);
      end else begin
        tmax[job_axis] <= TW'(div_quo);
      end
    end
    if (cmd.step) begin
      travel <= tmax[ax];
      tmax[ax] <= tmax[ax] + tdel[ax];
      it <= it + COUNT_W'(1);
      hav <= 1'b1;
      hax <= ax;
      for (int a = 0; a < 3; a++) begin
        vox[a] <= vox_next[a];
      end
    end
    if (cmd.set_miss) begin
      hit_flag <= 1'b0;
      hit_x <= '0;
      hit_y <= '0;
      hit_z <= '0;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= '0;
      hit_distance <= '0;
    end
    if (cmd.set_hit) begin
      hit_flag <= 1'b1;
      hit_x <= vox[0][OUT_VOX_W-1:0];
      hit_y <= vox[1][OUT_VOX_W-1:0];
      hit_z <= vox[2][OUT_VOX_W-1:0];
      normal_x <= (hav && hax == 2'd0) ? (dir[0][DIR_W-1] ? 2'sb01 : 2'sb11) : 2'sb00;
      normal_y <= (hav && hax == 2'd1) ? (dir[1][DIR_W-1] ? 2'sb01 : 2'sb11) : 2'sb00;
      normal_z <= (hav && hax == 2'd2) ? (dir[2][DIR_W-1] ? 2'sb01 : 2'sb11) : 2'sb00;
      hit_distance <= (travel > TW'(24'hFFFFFF)) ? 24'hFFFFFF : travel[23:0];
    end
  end

  always_comb begin
    st.clear_last = clr_addr == '1;
    st.is_write = !mode_q;
    st.no_cast = (md <= 0) || (dir[0] == '0 && dir[1] == '0 && dir[2] == '0);
    st.solid = ram_rdata && inr_q;
    st.div_done = div_done;
    st.step_end = (it >= ms) || !active[ax] || (tmax[ax] > TW'(unsigned'(md)));
  end

endmodule
`default_nettype wire

@@ hdl/vrt_ctrl.sv @@
`default_nettype none
module vrt_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire vrt_pkg::status_t st,
  output vrt_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  done
);

  import vrt_pkg::*;

  state_t     state, state_next;
  logic [2:0] job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      job <= '0;
    end else begin
      state <= state_next;
      job <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    job_next = job;
    unique case (state)
      S_CLEAR: begin
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (st.is_write || st.no_cast) state_next = S_DONE;
        else state_next = S_ORIG;
      end
      S_ORIG: begin
        job_next = '0;
        if (st.solid) state_next = S_DONE;
        else state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_next = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (st.div_done) begin
          if (job == JOB_LAST) begin
            state_next = S_STEP;
          end else begin
            job_next = job + 3'd1;
            state_next = S_DIV_GO;
          end
        end
      end
      S_STEP: begin
        if (st.step_end) state_next = S_DONE;
        else state_next = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (st.solid) state_next = S_DONE;
        else state_next = S_STEP;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_job = job;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cmd.grid_write = st.is_write;
        cmd.set_miss = st.is_write || st.no_cast;
      end
      S_ORIG: cmd.set_hit = st.solid;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_DIV_RUN: cmd.div_store = st.div_done;
      S_STEP: begin
        cmd.set_miss = st.step_end;
        cmd.step = !st.step_end;
      end
      S_STEP_WAIT: cmd.set_hit = st.solid;
      S_DONE: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/voxel_ray_traversal_hit.sv @@
`default_nettype none
// Voxel ray caster over a one-bit occupancy grid.
// An item is taken at a clock edge where start is high and busy is low.
// With mode low the item writes one occupancy bit; with mode high it casts a
// ray from the origin along the direction, up to max_distance.
// Every item yields exactly one result, shown for one cycle with done high;
// the receiver cannot hold it off. A write or a rejected ray shows its result,
// with every field zero, straight after the check state.
// A cast first reads the origin voxel and ends there with a hit if it is solid,
// then runs six divisions through one shared radix-2 divider, per axis the
// distance to the first boundary and the reciprocal distance per voxel, then
// steps voxel by voxel, each step waiting on the registered read of the grid.
// Busy falls in the cycle after the result.
// After reset the grid memory is cleared one voxel a cycle, and busy stays
// high until it is done.
module voxel_ray_traversal_hit #(
  parameter int GRID_SIDE_BITS = vrt_pkg::GRID_SIDE_BITS_DEF,
  parameter int FRAC_BITS = vrt_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode,
  input  wire logic [3:0]         cell_x,
  input  wire logic [3:0]         cell_y,
  input  wire logic [3:0]         cell_z,
  input  wire logic               solid_bit,
  input  wire logic signed [23:0] origin_x,
  input  wire logic signed [23:0] origin_y,
  input  wire logic signed [23:0] origin_z,
  input  wire logic signed [17:0] dir_x,
  input  wire logic signed [17:0] dir_y,
  input  wire logic signed [17:0] dir_z,
  input  wire logic signed [23:0] max_distance,
  output logic                    done,
  output logic                    hit_flag,
  output logic signed [9:0]       hit_x,
  output logic signed [9:0]       hit_y,
  output logic signed [9:0]       hit_z,
  output logic signed [1:0]       normal_x,
  output logic signed [1:0]       normal_y,
  output logic signed [1:0]       normal_z,
  output logic [23:0]             hit_distance
);

  import vrt_pkg::*;

  cmd_t    cmd;
  status_t st;

  vrt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  vrt_dp #(.GRID_SIDE_BITS(GRID_SIDE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .mode        (mode),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .solid_bit   (solid_bit),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .dir_z       (dir_z),
    .max_distance(max_distance),
    .hit_flag    (hit_flag),
    .hit_x       (hit_x),
    .hit_y       (hit_y),
    .hit_z       (hit_z),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .hit_distance(hit_distance)
  );

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("Result strobe lasted more than one cycle.");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("Block not busy after taking an item.");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit_flag) |-> (hit_x == 0 && hit_y == 0 && hit_z == 0 &&
      normal_x == 0 && normal_y == 0 && normal_z == 0 && hit_distance == 0))
    else $error("Miss result has non-zero fields.");
  a_one_normal: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({normal_x != 0, normal_y != 0, normal_z != 0}) <= 1))
    else $error("More than one normal axis set.");
`endif

endmodule
`default_nettype wire
